// ===== rtl/ltg_pkg.sv =====
// Shared types and constants of the toroidal life grid generation core.
package ltg_pkg;

   // Grid geometry
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ROW_AW   = $clog2(MAX_ROWS);
   localparam int COL_AW   = $clog2(MAX_COLS);
   localparam int SIZE_W   = 7;

   // Configuration register indexes
   localparam int CSR_AW = 1;
   localparam logic [CSR_AW-1:0] CSR_ROW_COUNT    = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_COLUMN_COUNT = 1'b1;

   // Request command codes
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_ADVANCE = 2'd2;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // B3/S23 neighbour counts
   localparam logic [3:0] SURVIVE_MIN = 4'd2;
   localparam logic [3:0] BIRTH_COUNT = 4'd3;

   typedef logic [ROW_AW-1:0]   row_addr_type;
   typedef logic [COL_AW-1:0]   col_addr_type;
   typedef logic [SIZE_W-1:0]   size_val_type;
   typedef logic [MAX_COLS-1:0] row_bits_type;
   typedef logic [3:0]          count_type;

   // Operation kinds after classification
   typedef enum logic [1:0] {
      OP_NOP,
      OP_WRITE,
      OP_READ,
      OP_ADVANCE
   } op_kind_type;

   typedef struct packed {
      op_kind_type  kind;
      row_addr_type row;
      col_addr_type col;
      logic         cell_bit;
   } op_type;

   // Area in use, already clamped to 1..MAX
   typedef struct packed {
      size_val_type rows;
      size_val_type cols;
   } size_type;

endpackage

// ===== rtl/life_torus_generation_core.sv =====
// Top level of the toroidal life grid generation core.
//
// Request channel (req_*): one command per request: write a cell, read a
// cell, or advance the whole grid by one generation under the B3/S23 rule.
// Response channel (rsp_*): exactly one response per request, in order;
// rsp_cell_out carries a read cell, rsp_generation_done marks an advance.
// Both channels move a request when valid is high and stall is low.
// Configuration (csr_*): row and column counts of the torus in use, written
// while no request is outstanding; values are clamped to 1..64.
// Path of a request: it enters the queue, and the back end takes it from there; a
// command that does nothing loads its response as it is taken, a cell read or write
// first reads its grid row, and an advance reads and rewrites every row in use before
// it responds. A two-entry queue decouples acceptance from execution. The back end
// runs one command at a time over a grid RAM with one read and one write port; an
// advance computes one full row per cycle.
// Reset clears the grid to all dead and sets both counts to 64, with no
// clearing pass. A stalled response holds in its register; the back end
// then waits and the queue fills, after which req_stall rises.
module life_torus_generation_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [5:0]                  req_row,
   input  logic [5:0]                  req_col,
   input  logic                        req_cell_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_cell_out,
   output logic                        rsp_generation_done,
   input  logic                        csr_wr_en,
   input  logic [ltg_pkg::CSR_AW-1:0]  csr_index,
   input  logic [ltg_pkg::SIZE_W-1:0]  csr_data
);

   ltg_pkg::size_type size_ff, size_in;
   ltg_pkg::op_type   op;
   logic              op_valid;
   logic              op_take;

   // clamp a written count to 1..max
   function automatic ltg_pkg::size_val_type clamp(input ltg_pkg::size_val_type v,
                                                   input ltg_pkg::size_val_type maxv);
      ltg_pkg::size_val_type r;
      r = v;
      if (v == '0) begin
         r = ltg_pkg::size_val_type'(1);
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

   // configuration registers
   always_comb begin
      size_in = size_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ltg_pkg::CSR_ROW_COUNT: begin
               size_in.rows = clamp(csr_data, ltg_pkg::size_val_type'(ltg_pkg::MAX_ROWS));
            end
            ltg_pkg::CSR_COLUMN_COUNT: begin
               size_in.cols = clamp(csr_data, ltg_pkg::size_val_type'(ltg_pkg::MAX_COLS));
            end
            default: begin
               size_in = size_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff.rows <= ltg_pkg::size_val_type'(ltg_pkg::MAX_ROWS);
         size_ff.cols <= ltg_pkg::size_val_type'(ltg_pkg::MAX_COLS);
      end else begin
         size_ff <= size_in;
      end
   end

   ltg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_cell_in (req_cell_in),
      .size        (size_ff),
      .op_valid    (op_valid),
      .op          (op),
      .op_take     (op_take)
   );

   ltg_back u_back (
      .clock               (clock),
      .reset               (reset),
      .size                (size_ff),
      .op_valid            (op_valid),
      .op                  (op),
      .op_take             (op_take),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cell_out        (rsp_cell_out),
      .rsp_generation_done (rsp_generation_done)
   );

endmodule

// ===== rtl/ltg_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module ltg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and read register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ltg_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module ltg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [5:0]        req_row,
   input  logic [5:0]        req_col,
   input  logic              req_cell_in,
   input  ltg_pkg::size_type size,
   output logic              op_valid,
   output ltg_pkg::op_type   op,
   input  logic              op_take
);

   ltg_pkg::op_type           entry_ff [ltg_pkg::QUEUE_DEPTH];
   logic [ltg_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ltg_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ltg_pkg::QCNT_W-1:0] count_ff, count_in;
   ltg_pkg::op_type           dec_op;
   logic                      in_area;
   logic                      push;

   // classify: cell commands outside the area in use do nothing
   always_comb begin
      in_area = ({1'b0, req_row} < size.rows) && ({1'b0, req_col} < size.cols);
      dec_op.row      = req_row;
      dec_op.col      = req_col;
      dec_op.cell_bit = req_cell_in;
      case (req_cmd)
         ltg_pkg::CMD_WRITE:   dec_op.kind = in_area ? ltg_pkg::OP_WRITE : ltg_pkg::OP_NOP;
         ltg_pkg::CMD_READ:    dec_op.kind = in_area ? ltg_pkg::OP_READ : ltg_pkg::OP_NOP;
         ltg_pkg::CMD_ADVANCE: dec_op.kind = ltg_pkg::OP_ADVANCE;
         default:              dec_op.kind = ltg_pkg::OP_NOP;
      endcase
   end

   // queue pointers
   always_comb begin
      req_stall = (count_ff == ltg_pkg::QCNT_W'(ltg_pkg::QUEUE_DEPTH));
      push      = req_valid && !req_stall;
      op_valid  = (count_ff != '0);
      op        = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ltg_pkg::QPTR_W'(ltg_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (op_take) begin
         rd_ptr_in = (rd_ptr_ff == ltg_pkg::QPTR_W'(ltg_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !op_take) begin
         count_in = count_ff + 1'b1;
      end else if (!push && op_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec_op;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ltg_pkg::QCNT_W'(ltg_pkg::QUEUE_DEPTH))
      else $error("request queue over its depth");

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      op_take |-> op_valid)
      else $error("back end took from an empty queue");
`endif

endmodule

// ===== rtl/ltg_back.sv =====
// Back end: executes cell commands and generation advances on the grid RAM.
module ltg_back (
   input  logic              clock,
   input  logic              reset,
   input  ltg_pkg::size_type size,
   input  logic              op_valid,
   input  ltg_pkg::op_type   op,
   output logic              op_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_cell_out,
   output logic              rsp_generation_done
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CELL,
      ST_ADV,
      ST_LAST
   } state_type;

   state_type                     state_ff, state_in;
   ltg_pkg::op_type               op_ff, op_in;
   ltg_pkg::size_val_type         k_ff, k_in;
   ltg_pkg::row_bits_type         w0_ff, w0_in, w1_ff, w1_in, save0_ff, save0_in;
   logic [ltg_pkg::MAX_ROWS-1:0]  valid_ff, valid_in;
   logic                          rd_vbit_ff, rd_vbit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_cell_out_ff, rsp_cell_out_in;
   logic                          rsp_done_ff, rsp_done_in;
   logic                          rd_en, wr_en;
   ltg_pkg::row_addr_type         rd_addr, wr_addr;
   ltg_pkg::row_bits_type         rd_data, wr_data, row_data;
   ltg_pkg::row_addr_type         last_row;
   ltg_pkg::col_addr_type         last_col;
   ltg_pkg::size_val_type         k_end;
   logic                          slot_free, load_rsp;

   // west neighbour of every column, wrapping at the last column in use
   function automatic ltg_pkg::row_bits_type west(input ltg_pkg::row_bits_type r,
                                                  input ltg_pkg::col_addr_type lc);
      ltg_pkg::row_bits_type w;
      w    = {r[ltg_pkg::MAX_COLS-2:0], r[ltg_pkg::MAX_COLS-1]};
      w[0] = r[lc];
      return w;
   endfunction

   // east neighbour of every column, wrapping at the last column in use
   function automatic ltg_pkg::row_bits_type east(input ltg_pkg::row_bits_type r,
                                                  input ltg_pkg::col_addr_type lc);
      ltg_pkg::row_bits_type e;
      e = {r[0], r[ltg_pkg::MAX_COLS-1:1]};
      for (int c = 0; c < ltg_pkg::MAX_COLS; c++) begin
         if (ltg_pkg::col_addr_type'(c) == lc) begin
            e[c] = r[0];
         end
      end
      return e;
   endfunction

   // one new row from the rows above, at and below it
   function automatic ltg_pkg::row_bits_type next_row(input ltg_pkg::row_bits_type up,
                                                      input ltg_pkg::row_bits_type mid,
                                                      input ltg_pkg::row_bits_type dn,
                                                      input ltg_pkg::col_addr_type lc);
      ltg_pkg::row_bits_type up_w, up_e, mid_w, mid_e, dn_w, dn_e, nxt;
      ltg_pkg::count_type    live;
      up_w  = west(up, lc);
      up_e  = east(up, lc);
      mid_w = west(mid, lc);
      mid_e = east(mid, lc);
      dn_w  = west(dn, lc);
      dn_e  = east(dn, lc);
      for (int c = 0; c < ltg_pkg::MAX_COLS; c++) begin
         live = ltg_pkg::count_type'(up_w[c]) + ltg_pkg::count_type'(up[c])
              + ltg_pkg::count_type'(up_e[c]) + ltg_pkg::count_type'(mid_w[c])
              + ltg_pkg::count_type'(mid_e[c]) + ltg_pkg::count_type'(dn_w[c])
              + ltg_pkg::count_type'(dn[c]) + ltg_pkg::count_type'(dn_e[c]);
         if (ltg_pkg::col_addr_type'(c) > lc) begin
            nxt[c] = 1'b0;
         end else if (mid[c]) begin
            nxt[c] = (live == ltg_pkg::SURVIVE_MIN) || (live == ltg_pkg::BIRTH_COUNT);
         end else begin
            nxt[c] = (live == ltg_pkg::BIRTH_COUNT);
         end
      end
      return nxt;
   endfunction

   // grid storage, one row per word
   ltg_ram #(
      .WIDTH (ltg_pkg::MAX_COLS),
      .DEPTH (ltg_pkg::MAX_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      slot_free = !rsp_valid_ff || !rsp_stall;
      op_take   = (state_ff == ST_IDLE) && op_valid && slot_free;
      row_data  = rd_data & {ltg_pkg::MAX_COLS{rd_vbit_ff}};
      last_row  = ltg_pkg::row_addr_type'(size.rows - 1'b1);
      last_col  = ltg_pkg::col_addr_type'(size.cols - 1'b1);
      k_end     = size.rows + 1'b1;

      state_in        = state_ff;
      op_in           = op_ff;
      k_in            = k_ff;
      w0_in           = w0_ff;
      w1_in           = w1_ff;
      save0_in        = save0_ff;
      valid_in        = valid_ff;
      rd_vbit_in      = rd_vbit_ff;
      rd_en           = 1'b0;
      rd_addr         = op.row;
      wr_en           = 1'b0;
      wr_addr         = op_ff.row;
      wr_data         = row_data;
      load_rsp        = 1'b0;
      rsp_cell_out_in = rsp_cell_out_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (op_take) begin
               op_in = op;
               case (op.kind)
                  ltg_pkg::OP_WRITE, ltg_pkg::OP_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = op.row;
                     state_in = ST_CELL;
                  end
                  ltg_pkg::OP_ADVANCE: begin
                     // rows outside the area become dead
                     for (int i = 0; i < ltg_pkg::MAX_ROWS; i++) begin
                        if (ltg_pkg::size_val_type'(i) >= size.rows) begin
                           valid_in[i] = 1'b0;
                        end
                     end
                     k_in     = '0;
                     state_in = ST_ADV;
                  end
                  default: begin
                     load_rsp        = 1'b1;
                     rsp_cell_out_in = 1'b0;
                     rsp_done_in     = 1'b0;
                  end
               endcase
            end
         end
         ST_CELL: begin
            load_rsp        = 1'b1;
            rsp_done_in     = 1'b0;
            rsp_cell_out_in = 1'b0;
            if (op_ff.kind == ltg_pkg::OP_WRITE) begin
               wr_en                = 1'b1;
               wr_addr              = op_ff.row;
               wr_data[op_ff.col]   = op_ff.cell_bit;
               valid_in[op_ff.row]  = 1'b1;
            end else begin
               rsp_cell_out_in = row_data[op_ff.col];
            end
            state_in = ST_IDLE;
         end
         ST_ADV: begin
            // read order: last row, then rows 0 to last
            if (k_ff <= size.rows) begin
               rd_en   = 1'b1;
               rd_addr = (k_ff == '0) ? last_row : ltg_pkg::row_addr_type'(k_ff - 1'b1);
            end
            // three rows in hand: write the new middle row in place
            if (k_ff >= ltg_pkg::size_val_type'(3)) begin
               wr_en           = 1'b1;
               wr_addr         = ltg_pkg::row_addr_type'(k_ff - ltg_pkg::size_val_type'(3));
               wr_data         = next_row(w0_ff, w1_ff, row_data, last_col);
               valid_in[wr_addr] = 1'b1;
            end
            // keep old row 0 for the wrap of the last row
            if (k_ff == ltg_pkg::size_val_type'(2)) begin
               save0_in = row_data;
            end
            if (k_ff != '0) begin
               w0_in = w1_ff;
               w1_in = row_data;
            end
            if (k_ff >= k_end) begin
               state_in = ST_LAST;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_LAST: begin
            wr_en              = 1'b1;
            wr_addr            = last_row;
            wr_data            = next_row(w0_ff, w1_ff, save0_ff, last_col);
            valid_in[last_row] = 1'b1;
            load_rsp           = 1'b1;
            rsp_cell_out_in    = 1'b0;
            rsp_done_in        = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rd_en) begin
         rd_vbit_in = valid_ff[rd_addr];
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff           <= op_in;
      k_ff            <= k_in;
      w0_ff           <= w0_in;
      w1_ff           <= w1_in;
      save0_ff        <= save0_in;
      rd_vbit_ff      <= rd_vbit_in;
      rsp_cell_out_ff <= rsp_cell_out_in;
      rsp_done_ff     <= rsp_done_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_out        = rsp_cell_out_ff;
   assign rsp_generation_done = rsp_done_ff;

`ifndef NO_ASSERTIONS
   a_no_same_row: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("grid row read and written in the same cycle");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV) |-> (k_ff <= ltg_pkg::size_val_type'(ltg_pkg::MAX_ROWS + 1)))
      else $error("advance step count out of range");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response loaded over an untaken response");
`endif

endmodule

// ===== tb/life_torus_generation_checker.sv =====
// Checker for the toroidal life core: predicts every response and compares it field by field.
module life_torus_generation_checker
   import ltg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [5:0]          req_row,
   input  logic [5:0]          req_col,
   input  logic                req_cell_in,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_cell_out,
   input  logic                rsp_generation_done,
   input  logic                csr_wr_en,
   input  logic [CSR_AW-1:0]   csr_index,
   input  size_val_type        csr_data,
   output int                  failures,
   output int                  pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic cell_out;
      logic generation_done;
   } cell_reply_type;

   // Model grid in two banks, the bank in use and shadows of the size registers
   row_bits_type bank [2][MAX_ROWS];
   bit           live_bank;
   size_val_type rows_reg;
   size_val_type cols_reg;

   cell_reply_type replies_due [$];
   int             fail_count = 0;

   // Size in use: register value clamped to 1..limit
   function automatic int extent(size_val_type v, int limit);
      if (v < 1) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   // Next generation of the live bank into the other one, then swap
   function automatic void step_generation();
      int           nr, nc, rr, cc, live;
      row_bits_type fresh [MAX_ROWS];
      logic         here;
      nr = extent(rows_reg, MAX_ROWS);
      nc = extent(cols_reg, MAX_COLS);
      for (int r = 0; r < MAX_ROWS; r++) fresh[r] = '0;
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            live = 0;
            // offsets -1..+1 wrap modulo the size; a tiny torus may count a cell twice
            for (int dr = 0; dr < 3; dr++) begin
               for (int dc = 0; dc < 3; dc++) begin
                  if (!(dr == 1 && dc == 1)) begin
                     rr = (r + nr - 1 + dr) % nr;
                     cc = (c + nc - 1 + dc) % nc;
                     live += int'(bank[live_bank][rr][cc]);
                  end
               end
            end
            here = bank[live_bank][r][c];
            if (here) fresh[r][c] = (live == 2 || live == 3);
            else      fresh[r][c] = (live == 3);
         end
      end
      for (int r = 0; r < MAX_ROWS; r++) bank[live_bank ^ 1'b1][r] = fresh[r];
      live_bank = live_bank ^ 1'b1;
   endfunction

   // Apply one request to the shadow state and return its response
   function automatic cell_reply_type predict_reply(logic [1:0] cmd, row_addr_type row,
                                                    col_addr_type col, logic cell_val);
      cell_reply_type reply;
      bit             in_area;
      reply   = '0;
      in_area = (int'(row) < extent(rows_reg, MAX_ROWS)) &&
                (int'(col) < extent(cols_reg, MAX_COLS));
      case (cmd)
         CMD_WRITE: begin
            if (in_area) bank[live_bank][row][col] = cell_val;
         end
         CMD_READ: begin
            if (in_area) reply.cell_out = bank[live_bank][row][col];
         end
         CMD_ADVANCE: begin
            step_generation();
            reply.generation_done = 1'b1;
         end
         default: ;
      endcase
      return reply;
   endfunction

   // Track registers, compare responses, queue predictions
   always @(posedge clock) begin
      cell_reply_type want;
      if (reset) begin
         for (int r = 0; r < MAX_ROWS; r++) begin
            bank[0][r] = '0;
            bank[1][r] = '0;
         end
         live_bank = 1'b0;
         rows_reg  = SIZE_W'(MAX_ROWS);
         cols_reg  = SIZE_W'(MAX_COLS);
         replies_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ROW_COUNT:    rows_reg = csr_data;
               CSR_COLUMN_COUNT: cols_reg = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $display("%0t: response with none outstanding: cell_out %0b generation_done %0b",
                        $time, rsp_cell_out, rsp_generation_done);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_cell_out !== want.cell_out) begin
                  $display("%0t: rsp_cell_out expected %0b actual %0b",
                           $time, want.cell_out, rsp_cell_out);
                  fail_count++;
               end
               if (rsp_generation_done !== want.generation_done) begin
                  $display("%0t: rsp_generation_done expected %0b actual %0b",
                           $time, want.generation_done, rsp_generation_done);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            replies_due.insert(replies_due.size(),
                               predict_reply(req_cmd, req_row, req_col, req_cell_in));
      end
      failures <= fail_count;
      pending  <= replies_due.size();
   end

endmodule

// ===== tb/life_torus_generation_core_tb.sv =====
// Testbench top for the toroidal life core: clock, reset, stimulus, stalls and verdict.
module life_torus_generation_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import ltg_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int PHASES      = 12;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG    = 4000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_cmd;
   logic [5:0]        req_row;
   logic [5:0]        req_col;
   logic              req_cell_in;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_cell_out;
   logic              rsp_generation_done;
   logic              csr_wr_en;
   logic [CSR_AW-1:0] csr_index;
   size_val_type      csr_data;

   int failures;
   int pending;

   logic req_taken = 1'b0;
   int   idle_cycles = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_ticket = 0;
   int   hold_seen = 0;
   int   hold_left = 0;

   int phase_rows [PHASES] = '{64, 1, 2, 3, 0, 127, 2, 64, 8, 16, 5, 40};
   int phase_cols [PHASES] = '{64, 1, 2, 5, 127, 0, 64, 3, 8, 12, 2, 40};

   always #2 clock = ~clock;

   life_torus_generation_core DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_row             (req_row),
      .req_col             (req_col),
      .req_cell_in         (req_cell_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cell_out        (rsp_cell_out),
      .rsp_generation_done (rsp_generation_done),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   life_torus_generation_checker reply_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_row             (req_row),
      .req_col             (req_col),
      .req_cell_in         (req_cell_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cell_out        (rsp_cell_out),
      .rsp_generation_done (rsp_generation_done),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .failures            (failures),
      .pending             (pending)
   );

   // Acceptance seen at the edge, and cycles since anything moved
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else                                                        idle_cycles <= idle_cycles + 1;
   end

   // Receiver: long hold-off on request, otherwise random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Watchdog on a stuck handshake
   initial begin
      do @(negedge clock); while (idle_cycles < WATCHDOG);
      $display("Test completed with failures");
      $finish;
   end

   // Offer one request, with random idle cycles ahead of it
   task automatic send_request(input int cmd, input int row, input int col, input int val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= 2'(cmd);
      req_row     <= row_addr_type'(row);
      req_col     <= col_addr_type'(col);
      req_cell_in <= 1'(val);
      do @(negedge clock); while (!req_taken);
   endtask

   // Stop offering, wait for every response, then stay quiet for the extra cycles asked for
   task automatic settle_block(input int extra);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_size(input int rows_v, input int cols_v);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ROW_COUNT;
      csr_data  <= SIZE_W'(rows_v);
      @(negedge clock);
      csr_index <= CSR_COLUMN_COUNT;
      csr_data  <= SIZE_W'(cols_v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idle(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 60 : (mode == IDLE_BOTH) ? 26 : 0;
      recv_idle_pct <= (mode == IDLE_RECEIVER) ? 60 : (mode == IDLE_BOTH) ? 26 : 0;
   endtask

   function automatic int area_extent(input int v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
   endfunction

   // Mostly seed-advance-read bursts around an anchor, some raw noise
   task automatic run_mix(input int count, input int nr, input int nc);
      int sent, k, adv, m, r0, c0;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 78) begin
            r0  = $urandom_range(0, nr - 1);
            c0  = $urandom_range(0, nc - 1);
            k   = $urandom_range(1, 7);
            adv = (nr * nc > 512) ? 1 : $urandom_range(1, 3);
            m   = $urandom_range(1, 5);
            repeat (k)
               send_request(CMD_WRITE, (r0 + $urandom_range(0, 2)) % nr,
                            (c0 + $urandom_range(0, 2)) % nc, $urandom_range(0, 4) != 0);
            repeat (adv)
               send_request(CMD_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 1));
            repeat (m)
               send_request(CMD_READ, (r0 + $urandom_range(0, 3)) % nr,
                            (c0 + $urandom_range(0, 3)) % nc, $urandom_range(0, 1));
            sent += k + adv + m;
         end else begin
            send_request($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1));
            sent++;
         end
      end
   endtask

   initial begin
      int rows_v, cols_v;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_WRITE;
      req_row     = '0;
      req_col     = '0;
      req_cell_in = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_ROW_COUNT;
      csr_data    = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: corner block across both wraps, a blinker, lonely cell, unused code
      send_request(CMD_WRITE, 0, 0, 1);
      send_request(CMD_WRITE, 0, 63, 1);
      send_request(CMD_WRITE, 63, 0, 1);
      send_request(CMD_WRITE, 63, 63, 1);
      send_request(CMD_READ, 0, 0, 0);
      send_request(CMD_READ, 63, 63, 1);
      send_request(CMD_READ, 1, 1, 0);
      send_request(CMD_WRITE, 10, 20, 1);
      send_request(CMD_WRITE, 10, 21, 1);
      send_request(CMD_WRITE, 10, 22, 1);
      send_request(CMD_UNUSED, 63, 63, 1);
      send_request(CMD_ADVANCE, 0, 0, 0);
      send_request(CMD_READ, 9, 21, 0);
      send_request(CMD_READ, 10, 20, 0);
      send_request(CMD_READ, 0, 0, 0);
      send_request(CMD_WRITE, 0, 0, 0);
      send_request(CMD_ADVANCE, 63, 63, 1);
      send_request(CMD_READ, 0, 0, 0);
      send_request(CMD_READ, 10, 21, 0);
      send_request(CMD_ADVANCE, 0, 0, 0);
      send_request(CMD_READ, 63, 0, 0);
      send_request(CMD_WRITE, 32, 32, 1);
      send_request(CMD_ADVANCE, 0, 0, 0);
      send_request(CMD_READ, 32, 32, 0);
      send_request(CMD_UNUSED, 0, 0, 0);

      // Random phases over a range of torus sizes and idling patterns
      for (int p = 0; p < PHASES; p++) begin
         rows_v = phase_rows[p];
         cols_v = phase_cols[p];
         if (p == PHASES - 1) begin
            rows_v = $urandom_range(1, 64);
            cols_v = $urandom_range(1, 64);
         end
         settle_block(8);
         write_size(rows_v, cols_v);
         set_idle(idle_mode_type'(p % 4));
         run_mix(50, area_extent(rows_v), area_extent(cols_v));
         // sender waits for every response mid-phase once
         if (p == 5) settle_block(0);
         // receiver holds off while the sender keeps offering
         if (p == 8) hold_ticket <= hold_ticket + 1;
         run_mix(55, area_extent(rows_v), area_extent(cols_v));
      end

      settle_block(80);
      if (failures == 0) $display("Test completed successfully");
      else               $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== life_torus_generation_core.f =====
rtl/ltg_pkg.sv
rtl/ltg_ram.sv
rtl/ltg_front.sv
rtl/ltg_back.sv
rtl/life_torus_generation_core.sv
tb/life_torus_generation_checker.sv
tb/life_torus_generation_core_tb.sv
